// ===== rtl/ms_adpcm_block_decoder_unit_macros.svh =====
// Assertion macros shared by the ADPCM block decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MS_ADPCM_BLOCK_DECODER_UNIT_MACROS_SVH
`define MS_ADPCM_BLOCK_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MADPCM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed in %m");
// Condition must never be true outside reset.
`define MADPCM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition in %m");
`else
`define MADPCM_ASSERT(lbl, clk, rst_n, prop)
`define MADPCM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/madpcm_pkg.sv =====
// Package for the ADPCM block decoder: command and result types, register
// indexes, coefficient and adaptation tables. No dependencies.
`timescale 1ns / 1ps

package madpcm_pkg;

  // defaults for top-level parameters
  localparam int unsigned NUM_PREDICTORS = 7;
  localparam int unsigned CMD_DEPTH      = 4;
  localparam int unsigned OUT_DEPTH      = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ALIGN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BLOCK = 2'd2;

  localparam logic [1:0]  RESET_CHANNEL_COUNT = 2'd1;
  localparam logic [15:0] RESET_BLOCK_ALIGN   = 16'd256;
  localparam logic [15:0] RESET_SPB           = 16'd500;
  localparam logic [1:0]  STEREO_CODE         = 2'd2;

  // arithmetic limits
  localparam logic signed [31:0] DELTA_FLOOR = 32'sd16;
  localparam logic signed [31:0] DELTA_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [15:0] SAMPLE_MIN  = -16'sd32768;
  localparam logic signed [15:0] SAMPLE_MAX  = 16'sd32767;

  typedef enum logic [1:0] {
    OP_BAD,
    OP_WRITE,
    OP_HDR,
    OP_DECODE
  } op_e;

  typedef enum logic [1:0] {
    FLD_DELTA,
    FLD_LAST,
    FLD_OLDER
  } fld_e;

  // front to back command
  typedef struct packed {
    op_e             op;
    fld_e            fld;      // header field for OP_WRITE / OP_HDR
    logic            chan;     // header channel, or channel of a bad index
    logic            stereo;
    logic            two_nib;  // mono byte that decodes both nibbles
    logic            done0;    // block_done for the first frame
    logic            done1;    // block_done for the second mono frame
    logic [1:0][2:0] pred;     // predictor index per channel
    logic [15:0]     value;    // header word, or data byte in [7:0]
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               run_last;
    logic               block_done;
    logic               bad_predictor;
  } res_t;

  function automatic logic signed [11:0] coef_a(input logic [2:0] idx);
    logic signed [11:0] c;
    case (idx)
      3'd0:    c = 12'sd256;
      3'd1:    c = 12'sd512;
      3'd2:    c = 12'sd0;
      3'd3:    c = 12'sd192;
      3'd4:    c = 12'sd240;
      3'd5:    c = 12'sd460;
      3'd6:    c = 12'sd392;
      default: c = 12'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [11:0] coef_b(input logic [2:0] idx);
    logic signed [11:0] c;
    case (idx)
      3'd0:    c = 12'sd0;
      3'd1:    c = -12'sd256;
      3'd2:    c = 12'sd0;
      3'd3:    c = 12'sd64;
      3'd4:    c = 12'sd0;
      3'd5:    c = -12'sd208;
      3'd6:    c = -12'sd232;
      default: c = 12'sd0;
    endcase
    return c;
  endfunction

  function automatic logic [9:0] adapt_val(input logic [3:0] nib);
    logic [9:0] a;
    case (nib)
      4'd4:    a = 10'd307;
      4'd5:    a = 10'd409;
      4'd6:    a = 10'd512;
      4'd7:    a = 10'd614;
      4'd8:    a = 10'd768;
      4'd9:    a = 10'd614;
      4'd10:   a = 10'd512;
      4'd11:   a = 10'd409;
      4'd12:   a = 10'd307;
      default: a = 10'd230;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/madpcm_fifo.sv =====
// Small synchronous FIFO used as command queue and as result buffer.
// Depends on the shared assertion macro header only.
`timescale 1ns / 1ps
`include "ms_adpcm_block_decoder_unit_macros.svh"

module madpcm_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `MADPCM_ASSERT_NEVER(a_fifo_overflow, clk_i, rst_ni, push_i && full_o)
  `MADPCM_ASSERT_NEVER(a_fifo_underflow, clk_i, rst_ni, pop_i && empty_o)
  `MADPCM_ASSERT(a_fifo_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(Depth))

endmodule

// ===== rtl/madpcm_front.sv =====
// Front end: configuration registers, block byte position, header parsing
// and classification of each byte into back-end commands. Uses madpcm_pkg.
`timescale 1ns / 1ps

module madpcm_front #(
  parameter int unsigned NumPredictors = madpcm_pkg::NUM_PREDICTORS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [madpcm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [madpcm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [7:0]                            data_byte_i,
  input  logic                                  cmd_full_i,
  output logic                                  cmd_push_o,
  output madpcm_pkg::cmd_t                      cmd_o
);

  logic [1:0]  chan_cnt_q;
  logic [15:0] blk_align_q;
  logic [15:0] spb_q;

  logic [15:0]      pos_q, pos_d;
  logic [15:0]      fc_q, fc_d;
  logic [1:0][2:0]  pred_q, pred_d;
  logic [7:0]       latch_q, latch_d;
  logic             skip_q, skip_d;

  logic        in_acc;
  logic        stereo;
  logic [15:0] nch, hdr_len, spb_eff;
  logic [16:0] fc1, fc2, spb17;
  logic [3:0]  off;
  logic        bad_idx;
  logic        blk_end;

  assign in_stall_o = cmd_full_i;
  assign in_acc     = in_valid_i & ~cmd_full_i;

  // derived configuration
  assign stereo  = (chan_cnt_q == madpcm_pkg::STEREO_CODE);
  assign nch     = stereo ? 16'd2 : 16'd1;
  assign hdr_len = stereo ? 16'd14 : 16'd7;
  assign spb_eff = (spb_q < 16'd2) ? 16'd2 : spb_q;
  assign spb17   = {1'b0, spb_eff};
  assign fc1     = {1'b0, fc_q} + 17'd1;
  assign fc2     = {1'b0, fc_q} + 17'd2;
  assign off     = pos_q[3:0] - (stereo ? 4'd2 : 4'd1);
  assign bad_idx = ({1'b0, data_byte_i} >= 9'(NumPredictors));
  assign blk_end = (pos_q == (blk_align_q - 16'd1));

  // classify the byte
  always_comb begin
    pos_d      = pos_q;
    fc_d       = fc_q;
    pred_d     = pred_q;
    latch_d    = latch_q;
    skip_d     = skip_q;
    cmd_push_o = 1'b0;
    cmd_o         = '0;
    cmd_o.op      = madpcm_pkg::OP_DECODE;
    cmd_o.stereo  = stereo;
    cmd_o.pred    = pred_q;
    cmd_o.value   = {8'd0, data_byte_i};
    cmd_o.chan    = stereo & off[1];
    cmd_o.fld     = stereo ? madpcm_pkg::fld_e'(off[3:2]) : madpcm_pkg::fld_e'(off[2:1]);
    if (in_acc) begin
      if (!skip_q) begin
        if (pos_q < nch) begin
          // predictor index bytes
          if (bad_idx) begin
            cmd_push_o = 1'b1;
            cmd_o.op   = madpcm_pkg::OP_BAD;
            cmd_o.chan = pos_q[0];
            skip_d     = 1'b1;
          end else begin
            pred_d[pos_q[0]] = data_byte_i[2:0];
          end
        end else if (pos_q < hdr_len) begin
          // little-endian header words
          if (!off[0]) begin
            latch_d = data_byte_i;
          end else begin
            cmd_push_o  = 1'b1;
            cmd_o.value = {data_byte_i, latch_q};
            cmd_o.op    = (pos_q == hdr_len - 16'd1) ? madpcm_pkg::OP_HDR
                                                     : madpcm_pkg::OP_WRITE;
          end
          if (pos_q == hdr_len - 16'd1) begin
            fc_d        = 16'd2;
            cmd_o.done0 = (spb_eff == 16'd2);
          end
        end else if (fc_q < spb_eff) begin
          // coded data byte
          cmd_push_o = 1'b1;
          if (stereo) begin
            fc_d        = fc1[15:0];
            cmd_o.done0 = (fc1 == spb17);
            cmd_o.done1 = (fc1 == spb17);
          end else begin
            cmd_o.done0   = (fc1 == spb17);
            cmd_o.two_nib = (fc1 < spb17);
            cmd_o.done1   = (fc2 == spb17);
            fc_d          = (fc1 < spb17) ? fc2[15:0] : fc1[15:0];
          end
        end
      end
      // block wrap
      if (blk_end) begin
        pos_d  = '0;
        fc_d   = '0;
        skip_d = 1'b0;
      end else begin
        pos_d = pos_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q  <= madpcm_pkg::RESET_CHANNEL_COUNT;
      blk_align_q <= madpcm_pkg::RESET_BLOCK_ALIGN;
      spb_q       <= madpcm_pkg::RESET_SPB;
      pos_q       <= '0;
      fc_q        <= '0;
      pred_q      <= '0;
      latch_q     <= '0;
      skip_q      <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      fc_q    <= fc_d;
      pred_q  <= pred_d;
      latch_q <= latch_d;
      skip_q  <= skip_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          madpcm_pkg::REG_CHANNEL_COUNT:     chan_cnt_q  <= cfg_data_i[1:0];
          madpcm_pkg::REG_BLOCK_ALIGN:       blk_align_q <= cfg_data_i;
          madpcm_pkg::REG_SAMPLES_PER_BLOCK: spb_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/madpcm_back.sv =====
// Back end: per-channel decoder state, header emit and two-lane nibble
// decode (multiply stage, then add/clamp/adapt stage). Uses madpcm_pkg.
`timescale 1ns / 1ps
`include "ms_adpcm_block_decoder_unit_macros.svh"

module madpcm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  madpcm_pkg::cmd_t  cmd_i,
  output logic              cmd_pop_o,
  input  logic              out_full_i,
  output logic              res_push_o,
  output madpcm_pkg::res_t  res_o
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_EMIT,
    B_MUL,
    B_ADD,
    B_PUSH2
  } state_e;

  state_e state_q, state_d;
  logic       phase_q, phase_d;
  logic [1:0] emit_q, emit_d;

  logic signed [31:0] delta_q [2];
  logic signed [31:0] delta_d [2];
  logic signed [15:0] last_q  [2];
  logic signed [15:0] last_d  [2];
  logic signed [15:0] older_q [2];
  logic signed [15:0] older_d [2];

  // multiply stage registers
  logic signed [27:0] p1_q [2];
  logic signed [27:0] p2_q [2];
  logic signed [36:0] ps_q [2];
  logic signed [42:0] pd_q [2];
  logic signed [15:0] rec1_q, rec1_d;
  logic               mul_en;

  // lane signals
  logic [3:0]         nib   [2];
  logic signed [11:0] ca    [2];
  logic signed [11:0] cb    [2];
  logic signed [4:0]  sn    [2];
  logic signed [10:0] ad    [2];
  logic signed [27:0] p1_n  [2];
  logic signed [27:0] p2_n  [2];
  logic signed [36:0] ps_n  [2];
  logic signed [42:0] pd_n  [2];
  logic signed [28:0] sum   [2];
  logic signed [20:0] pred  [2];
  logic signed [37:0] tot   [2];
  logic signed [15:0] rec   [2];
  logic [34:0]        qd    [2];
  logic signed [31:0] nd    [2];

  logic       last_emit;
  logic       emit_hi;
  logic       emit_ch;
  logic signed [15:0] hdr_val;

  // lane products
  always_comb begin
    nib[0] = phase_q ? cmd_i.value[3:0] : cmd_i.value[7:4];
    nib[1] = cmd_i.value[3:0];
    for (int l = 0; l < 2; l++) begin
      ca[l]   = madpcm_pkg::coef_a(cmd_i.pred[l]);
      cb[l]   = madpcm_pkg::coef_b(cmd_i.pred[l]);
      sn[l]   = $signed({nib[l][3], nib[l]});
      ad[l]   = $signed({1'b0, madpcm_pkg::adapt_val(nib[l])});
      p1_n[l] = 28'(last_q[l]) * 28'(ca[l]);
      p2_n[l] = 28'(older_q[l]) * 28'(cb[l]);
      ps_n[l] = 37'(sn[l]) * 37'(delta_q[l]);
      pd_n[l] = 43'(ad[l]) * 43'(delta_q[l]);
    end
  end

  // lane prediction, clamp and step adaptation
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l]  = 29'(p1_q[l]) + 29'(p2_q[l]);
      pred[l] = 21'(sum[l] >>> 8) + 21'((sum[l] < 0) && (sum[l][7:0] != 8'd0));
      tot[l]  = 38'(pred[l]) + 38'(ps_q[l]);
      if (tot[l] < 38'(madpcm_pkg::SAMPLE_MIN)) begin
        rec[l] = madpcm_pkg::SAMPLE_MIN;
      end else if (tot[l] > 38'(madpcm_pkg::SAMPLE_MAX)) begin
        rec[l] = madpcm_pkg::SAMPLE_MAX;
      end else begin
        rec[l] = 16'(tot[l]);
      end
      qd[l] = pd_q[l][42:8];
      if (pd_q[l][42]) begin
        nd[l] = madpcm_pkg::DELTA_FLOOR;
      end else if (qd[l] > 35'(madpcm_pkg::DELTA_MAX)) begin
        nd[l] = madpcm_pkg::DELTA_MAX;
      end else if (qd[l] < 35'(madpcm_pkg::DELTA_FLOOR)) begin
        nd[l] = madpcm_pkg::DELTA_FLOOR;
      end else begin
        nd[l] = 32'(qd[l]);
      end
    end
  end

  // header frame selection: older samples first, then last samples
  assign emit_hi   = cmd_i.stereo ? emit_q[1] : emit_q[0];
  assign emit_ch   = cmd_i.stereo & emit_q[0];
  assign hdr_val   = emit_hi ? last_q[emit_ch] : older_q[emit_ch];
  assign last_emit = (emit_q == (cmd_i.stereo ? 2'd3 : 2'd1));

  // sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    emit_d     = emit_q;
    delta_d    = delta_q;
    last_d     = last_q;
    older_d    = older_q;
    rec1_d     = rec1_q;
    mul_en     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            madpcm_pkg::OP_BAD: begin
              if (!out_full_i) begin
                res_push_o          = 1'b1;
                res_o.channel       = cmd_i.chan;
                res_o.run_last      = 1'b1;
                res_o.bad_predictor = 1'b1;
                cmd_pop_o           = 1'b1;
              end
            end
            madpcm_pkg::OP_WRITE, madpcm_pkg::OP_HDR: begin
              unique case (cmd_i.fld)
                madpcm_pkg::FLD_DELTA: delta_d[cmd_i.chan] = 32'($signed(cmd_i.value));
                madpcm_pkg::FLD_LAST:  last_d[cmd_i.chan]  = $signed(cmd_i.value);
                madpcm_pkg::FLD_OLDER: older_d[cmd_i.chan] = $signed(cmd_i.value);
                default: ;
              endcase
              if (cmd_i.op == madpcm_pkg::OP_HDR) begin
                state_d = B_EMIT;
                emit_d  = '0;
              end else begin
                cmd_pop_o = 1'b1;
              end
            end
            madpcm_pkg::OP_DECODE: begin
              mul_en  = 1'b1;
              phase_d = 1'b0;
              state_d = B_ADD;
            end
          endcase
        end
      end
      B_EMIT: begin
        if (!out_full_i) begin
          res_push_o       = 1'b1;
          res_o.sample     = hdr_val;
          res_o.channel    = emit_ch;
          res_o.block_done = emit_hi & cmd_i.done0;
          res_o.run_last   = last_emit;
          if (last_emit) begin
            cmd_pop_o = 1'b1;
            state_d   = B_IDLE;
          end else begin
            emit_d = emit_q + 2'd1;
          end
        end
      end
      B_MUL: begin
        mul_en  = 1'b1;
        state_d = B_ADD;
      end
      B_ADD: begin
        if (!out_full_i) begin
          delta_d[0] = nd[0];
          last_d[0]  = rec[0];
          older_d[0] = last_q[0];
          if (cmd_i.stereo) begin
            delta_d[1] = nd[1];
            last_d[1]  = rec[1];
            older_d[1] = last_q[1];
          end
          rec1_d           = rec[1];
          res_push_o       = 1'b1;
          res_o.sample     = rec[0];
          res_o.block_done = phase_q ? cmd_i.done1 : cmd_i.done0;
          if (cmd_i.stereo) begin
            state_d = B_PUSH2;
          end else if (!phase_q && cmd_i.two_nib) begin
            phase_d = 1'b1;
            state_d = B_MUL;
          end else begin
            res_o.run_last = 1'b1;
            phase_d        = 1'b0;
            cmd_pop_o      = 1'b1;
            state_d        = B_IDLE;
          end
        end
      end
      B_PUSH2: begin
        if (!out_full_i) begin
          res_push_o       = 1'b1;
          res_o.sample     = rec1_q;
          res_o.channel    = 1'b1;
          res_o.block_done = cmd_i.done0;
          res_o.run_last   = 1'b1;
          cmd_pop_o        = 1'b1;
          state_d          = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      phase_q <= 1'b0;
      emit_q  <= '0;
      for (int c = 0; c < 2; c++) begin
        delta_q[c] <= madpcm_pkg::DELTA_FLOOR;
        last_q[c]  <= '0;
        older_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      emit_q  <= emit_d;
      delta_q <= delta_d;
      last_q  <= last_d;
      older_q <= older_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    rec1_q <= rec1_d;
    if (mul_en) begin
      p1_q <= p1_n;
      p2_q <= p2_n;
      ps_q <= ps_n;
      pd_q <= pd_n;
    end
  end

  `MADPCM_ASSERT(a_push2_stereo, clk_i, rst_ni,
                 (state_q != B_PUSH2) || (cmd_valid_i && cmd_i.stereo))
  `MADPCM_ASSERT(a_emit_hdr, clk_i, rst_ni,
                 (state_q != B_EMIT) || (cmd_valid_i && cmd_i.op == madpcm_pkg::OP_HDR))
  `MADPCM_ASSERT(a_add_after_mul, clk_i, rst_ni,
                 $rose(state_q == B_ADD) |-> ($past(mul_en)))

endmodule

// ===== rtl/ms_adpcm_block_decoder_unit.sv =====
// Top level of the MS ADPCM block decoder: front end, command queue,
// back end and result buffer. Uses madpcm_pkg and the modules in rtl.
//
// Usage:
//   Input channel: one compressed block byte per item (data_byte_i) under
//   in_valid_i / in_stall_o. Output channel: one PCM sample per item with
//   channel, run_last, block_done and bad_predictor flags under
//   out_valid_o / out_stall_i. Configuration registers (channel count,
//   block align, samples per block) are for the user to write, via cfg_we_i,
//   cfg_idx_i and cfg_data_i, only while the block is idle; it is not enforced.
//   A data byte's command passes the command queue and the multiply stage
//   registers before its samples enter the result buffer. The back end
//   takes a stereo byte through multiply, add and PUSH2 states and a mono
//   byte as two dependent nibbles, each a multiply then an add state, and
//   starts no new command until it has popped the last one.
//   The front end takes a byte every cycle while the command queue has room.
//   Reset restores the register defaults (mono, 256, 500) and starts at the
//   first byte of a block. A stalled receiver fills the result buffer, then
//   the command queue, and then in_stall_o rises.
`timescale 1ns / 1ps

module ms_adpcm_block_decoder_unit #(
  parameter int unsigned NumPredictors = madpcm_pkg::NUM_PREDICTORS,
  parameter int unsigned CmdDepth      = madpcm_pkg::CMD_DEPTH,
  parameter int unsigned OutDepth      = madpcm_pkg::OUT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [madpcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [madpcm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                sample_o,
  output logic                              channel_o,
  output logic                              run_last_o,
  output logic                              block_done_o,
  output logic                              bad_predictor_o
);

  madpcm_pkg::cmd_t cmd_in, cmd_head;
  madpcm_pkg::res_t res_in, res_head;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full, res_pop, res_empty;

  madpcm_front #(
    .NumPredictors(NumPredictors)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // command queue between front and back
  madpcm_fifo #(
    .T    (madpcm_pkg::cmd_t),
    .Depth(CmdDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head),
    .empty_o(cmd_empty)
  );

  madpcm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(~cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .out_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // result buffer toward the receiver
  madpcm_fifo #(
    .T    (madpcm_pkg::res_t),
    .Depth(OutDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (res_pop),
    .data_o (res_head),
    .empty_o(res_empty)
  );

  assign out_valid_o     = ~res_empty;
  assign res_pop         = out_valid_o & ~out_stall_i;
  assign sample_o        = res_head.sample;
  assign channel_o       = res_head.channel;
  assign run_last_o      = res_head.run_last;
  assign block_done_o    = res_head.block_done;
  assign bad_predictor_o = res_head.bad_predictor;

endmodule
